### sv/swpr_pkg.sv
// swpr_pkg: shared types, constants and helpers of the sliding window packet receiver
// no dependencies; used by every module of the block but swpr_ram
`default_nettype none

package swpr_pkg;

  // default sizing, handed to the top level parameters
  localparam int SLOTS_DEF      = 8;
  localparam int MAX_PACKET_DEF = 1034;

  // frame constants
  localparam logic [7:0] HEAD_ACK   = 8'h06;
  localparam logic [7:0] HEAD_NAK   = 8'h21;
  localparam logic [7:0] START_MARK = 8'h01;

  // register reset values
  localparam logic [3:0]  INIT_WINDOW = 4'd8;
  localparam logic [31:0] INIT_TOP    = 32'd10;

  // response kind codes
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_NAK = 1'b1;

  // serial remainder unit: digit bits per cycle and cycles per 32-bit operand
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = 32 / MOD_DIGIT;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 1'd0,
    REG_INITIAL_TOP = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOD_S,
    S_CMP_S,
    S_NEXT,
    S_MOD_NX,
    S_CMP_NX,
    S_TOP,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic eval;
    logic mod_start;
    logic mod_nx;
    logic rd_en;
    logic store;
    logic release_nx;
    logic set_top;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic pkt_ok;
    logic mod_done;
    logic match_s;
    logic match_nx;
    logic rel_last;
  } stat_t;

  // inverted folded byte sum, carry dropped; only the low 16 bits of the sum matter
  function automatic logic [7:0] fold_check(input logic [15:0] sum);
    logic [7:0] folded;
    folded = sum[7:0] + sum[15:8];
    return ~folded;
  endfunction

endpackage

`default_nettype wire

### sv/swpr_ram.sv
// swpr_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module swpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/swpr_mod.sv
// swpr_mod: serial remainder of a 32-bit value by a 4-bit divisor, one digit per cycle
// depends on swpr_pkg
`default_nettype none

module swpr_mod
  import swpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] opnd_i,
  input  wire logic [3:0]  div_i,
  output logic             done_o,
  output logic      [3:0]  rem_o
);

  localparam int STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [31:0]       opnd_q;
  logic [3:0]        div_q;
  logic [3:0]        part_q;
  logic [3:0]        part_d;
  logic              done_q;
  logic [3:0]        rem_q;

  // one restoring step per bit of the digit
  always_comb begin
    logic [4:0] r;
    r = {1'b0, part_q};
    for (int i = 0; i < MOD_DIGIT; i++) begin
      r = {r[3:0], opnd_q[31-i]};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
      end
    end
    part_d = r[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= opnd_i;
      div_q  <= div_i;
      part_q <= '0;
    end else if (busy_q) begin
      opnd_q <= {opnd_q[31-MOD_DIGIT:0], {MOD_DIGIT{1'b0}}};
      part_q <= part_d;
      if (step_q == STEP_W'(MOD_STEPS - 1)) begin
        rem_q <= part_d;
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### sv/swpr_ctrl.sv
// swpr_ctrl: controller state machine of the packet receiver, owns the handshakes
// depends on swpr_pkg; drives the datapath through cmd_t and reads stat_t
`default_nettype none

module swpr_ctrl
  import swpr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  last_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && last_i && !stat_i.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = S_MOD_S;
      S_MOD_S: begin
        if (!stat_i.pkt_ok) begin
          state_d = S_RESP;
        end else if (stat_i.mod_done) begin
          state_d = S_CMP_S;
        end
      end
      S_CMP_S: state_d = stat_i.match_s ? S_RESP : S_NEXT;
      S_NEXT:  state_d = S_MOD_NX;
      S_MOD_NX: begin
        if (stat_i.mod_done) begin
          state_d = S_CMP_NX;
        end
      end
      S_CMP_NX: begin
        if (stat_i.match_nx && !stat_i.rel_last) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i && !stat_i.done;
      end
      S_CHECK: begin
        cmd_o.eval      = 1'b1;
        cmd_o.mod_start = 1'b1;
      end
      S_MOD_S: cmd_o.rd_en = stat_i.pkt_ok && stat_i.mod_done;
      S_CMP_S: cmd_o.store = !stat_i.match_s;
      S_NEXT: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_nx    = 1'b1;
      end
      S_MOD_NX: cmd_o.rd_en = stat_i.mod_done;
      S_CMP_NX: cmd_o.release_nx = stat_i.match_nx;
      S_TOP:    cmd_o.set_top = 1'b1;
      S_RESP:   cmd_o.load_out = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/swpr_dp.sv
// swpr_dp: datapath of the packet receiver: header capture, checksum, window and slot table
// depends on swpr_pkg, swpr_mod and swpr_ram
`default_nettype none

module swpr_dp
  import swpr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic                      response_kind_o,
  output logic      [31:0]          next_expected_o,
  output logic      [7:0]           response_check_o,
  output logic      [3:0]           released_count_o,
  output logic                      stored_new_o,
  output logic                      finished_o
);

  localparam int CNT_W   = $clog2(MAX_PACKET + 1);
  localparam int SUM_W   = $clog2(MAX_PACKET * 255 + 1);
  localparam int REL_W   = $clog2(SLOTS + 1);
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WMAX    = (SLOTS > 15) ? 15 : SLOTS;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       start_q, start_d;
  logic [31:0]      seq_q, seq_d;
  logic [31:0]      len_q, len_d;
  logic [31:0]      lio_q;
  logic [31:0]      top_q;
  logic [3:0]       ws_q;
  logic             done_q;
  logic             valid_q, ok_q, fin_q, stored_q;
  logic [REL_W-1:0] rel_q;
  logic [SLOTS-1:0] vld_q;
  logic             rd_vld_q;

  logic [3:0]         win;
  logic               pkt_valid;
  logic               in_win;
  logic [31:0]        nx;
  logic               mod_done;
  logic [3:0]         rem;
  logic [SLOT_AW-1:0] slot_addr;
  logic [31:0]        rdata;
  logic [31:0]        slot_val;
  logic [10:0]        resp_sum;
  logic [7:0]         head;

  // effective window: zero acts as one, clamp to the slot count and to 15
  always_comb begin
    win = ws_q;
    if (ws_q == 4'd0) begin
      win = 4'd1;
    end else if (ws_q > 4'(WMAX)) begin
      win = 4'(WMAX);
    end
  end

  // byte capture; bytes past the size limit are dropped
  always_comb begin
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    start_d = start_q;
    seq_d   = seq_q;
    len_d   = len_q;
    if (cmd_i.take_byte && cnt_q < CNT_W'(MAX_PACKET)) begin
      if (cnt_q == '0) begin
        sum_d   = '0;
        start_d = rx_byte_i;
        seq_d   = '0;
        len_d   = '0;
      end else begin
        sum_d = sum_q + SUM_W'(prev_q);
      end
      case (cnt_q)
        CNT_W'(1): seq_d[31:24] = rx_byte_i;
        CNT_W'(2): seq_d[23:16] = rx_byte_i;
        CNT_W'(3): seq_d[15:8]  = rx_byte_i;
        CNT_W'(4): seq_d[7:0]   = rx_byte_i;
        CNT_W'(5): len_d[31:24] = rx_byte_i;
        CNT_W'(6): len_d[23:16] = rx_byte_i;
        CNT_W'(7): len_d[15:8]  = rx_byte_i;
        CNT_W'(8): len_d[7:0]   = rx_byte_i;
        default: ;
      endcase
      prev_d = rx_byte_i;
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (cmd_i.eval) begin
      cnt_d = '0;
      sum_d = '0;
    end
  end

  assign pkt_valid = (start_q == START_MARK) && (fold_check(16'(sum_q)) == prev_q);
  assign in_win    = (seq_q > lio_q) && (seq_q <= top_q);
  assign nx        = lio_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      prev_q   <= '0;
      start_q  <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      lio_q    <= '0;
      top_q    <= INIT_TOP;
      ws_q     <= INIT_WINDOW;
      done_q   <= 1'b0;
      valid_q  <= 1'b0;
      ok_q     <= 1'b0;
      fin_q    <= 1'b0;
      stored_q <= 1'b0;
      rel_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_index_i) == REG_WINDOW_SIZE) begin
          ws_q <= cfg_data_i[3:0];
        end else if (cfg_reg_e'(cfg_index_i) == REG_INITIAL_TOP) begin
          top_q <= cfg_data_i;
        end
      end
      if (cmd_i.eval) begin
        valid_q  <= pkt_valid;
        ok_q     <= pkt_valid && in_win;
        fin_q    <= pkt_valid && (len_q == 32'd0);
        stored_q <= 1'b0;
        rel_q    <= '0;
      end
      if (cmd_i.store) begin
        vld_q[slot_addr] <= 1'b1;
        stored_q         <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[slot_addr];
      end
      if (cmd_i.release_nx) begin
        lio_q <= nx;
        rel_q <= rel_q + REL_W'(1);
      end
      if (cmd_i.set_top) begin
        top_q <= lio_q + 32'(win);
      end
      if (cmd_i.load_out && fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  swpr_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .opnd_i  (cmd_i.mod_nx ? nx : seq_q),
    .div_i   (win),
    .done_o  (mod_done),
    .rem_o   (rem)
  );

  assign slot_addr = SLOT_AW'(rem);

  swpr_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (slot_addr),
    .wdata_i (seq_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (slot_addr),
    .rdata_o (rdata)
  );

  // slot never written reads as zero
  assign slot_val = rd_vld_q ? rdata : 32'd0;

  assign stat_o.done     = done_q;
  assign stat_o.pkt_ok   = ok_q;
  assign stat_o.mod_done = mod_done;
  assign stat_o.match_s  = (slot_val == seq_q);
  assign stat_o.match_nx = (slot_val == nx);
  assign stat_o.rel_last = (rel_q == REL_W'(SLOTS - 1));

  assign head     = valid_q ? HEAD_ACK : HEAD_NAK;
  assign resp_sum = 11'(head) + 11'(nx[31:24]) + 11'(nx[23:16]) + 11'(nx[15:8])
                  + 11'(nx[7:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      response_kind_o  <= valid_q ? KIND_ACK : KIND_NAK;
      next_expected_o  <= nx;
      response_check_o <= fold_check(16'(resp_sum));
      released_count_o <= 4'(rel_q);
      stored_new_o     <= stored_q;
      finished_o       <= fin_q;
    end
  end

endmodule

`default_nettype wire

### sv/sliding_window_packet_receiver.sv
// sliding_window_packet_receiver: top level, joins controller and datapath
// depends on swpr_pkg, swpr_ctrl and swpr_dp
`default_nettype none

// Receiver side of a selective-repeat link. Datagram bytes arrive one per transfer with a
// last flag; every datagram that is taken before the transfer has finished gives exactly one
// ACK or NAK result carrying the next expected number and its checksum byte. A byte that is
// not the last is taken in the idle state. On the last byte the block stops taking input and
// works the packet end: check, then the response for a NAK or an out-of-window packet; else
// the slot remainder and compare, then the response for a duplicate; a stored packet probes
// slots (next, remainder, compare), one per frame released plus one or SLOTS when a whole
// table is released, and sets the window top. The response also waits while the previous
// result is held in the output register. The serial remainder unit finds a slot index four
// bits a cycle; the slot table read is registered. The slot table comes out of reset empty
// through per-slot valid bits, so no clearing pass is run. A finished result waits in the
// output register while the next datagram streams in. Configuration writes are taken in any
// cycle and belong to the idle block; writing initial_top reloads the window top at once.
module sliding_window_packet_receiver
  import swpr_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      response_kind_o,
  output logic      [31:0]          next_expected_o,
  output logic      [7:0]           response_check_o,
  output logic      [3:0]           released_count_o,
  output logic                      stored_new_o,
  output logic                      finished_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  swpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  swpr_dp #(
    .SLOTS      (SLOTS),
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .response_kind_o  (response_kind_o),
    .next_expected_o  (next_expected_o),
    .response_check_o (response_check_o),
    .released_count_o (released_count_o),
    .stored_new_o     (stored_new_o),
    .finished_o       (finished_o)
  );

  // input stalls only after the last byte of a datagram was taken
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && last_i))
    else $error("input stalled without a last byte transfer");

  // a NAK neither stores nor releases nor finishes
  a_nak_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && response_kind_o == KIND_NAK) |->
      (released_count_o == 4'd0 && !stored_new_o && !finished_o))
    else $error("NAK result with store, release or finish");

  // frames are released only by a packet that was stored
  a_release_needs_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stored_new_o) |-> (released_count_o == 4'd0))
    else $error("release without a store");

endmodule

`default_nettype wire
